@@ rtl/core/dlyt_pkg.sv @@
// Shared types and constants for the delayed-on / auto-off output timer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package dlyt_pkg;

	localparam int TIME_BITS_DEF = 32;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DUR_W     = 32;
	localparam int PCT_W     = 8;
	localparam int PROD_W    = CFG_W + PCT_W;

	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_OFF_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_OFF_MS = 2'd2;

	typedef enum logic [2:0] {
		ACT_TICK    = 3'd0,
		ACT_ON      = 3'd1,
		ACT_ON_TIME = 3'd2,
		ACT_ON_PCT  = 3'd3,
		ACT_OFF     = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		PH_OFF  = 2'd0,
		PH_WAIT = 2'd1,
		PH_ON   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0]       action;
		logic             force_req;
		logic [DUR_W-1:0] duration_ms;
		logic [PCT_W-1:0] percentage;
	} item_t;

	typedef struct packed {
		logic             drive_strobe;
		logic             auto_off_event;
		logic [1:0]       phase;
		logic             output_on;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] on_delay_ms;
		logic             auto_off_enable;
		logic [CFG_W-1:0] auto_off_ms;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/core/dlyt_cfg.sv @@
// Configuration register file of the output timer: on-delay, auto-off enable, auto-off time.
// Depends on dlyt_pkg.
`default_nettype none

module dlyt_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dlyt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dlyt_pkg::CFG_W-1:0]     cfg_data,
	output dlyt_pkg::cfg_t                      cfg
);

	dlyt_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dlyt_pkg::CFG_ON_DELAY:    cfg_q.on_delay_ms     <= cfg_data;
				dlyt_pkg::CFG_AUTO_OFF_EN: cfg_q.auto_off_enable <= cfg_data[0];
				dlyt_pkg::CFG_AUTO_OFF_MS: cfg_q.auto_off_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/dlyt_in.sv @@
// Input register stage: captures one item from the slave stream and holds it
// until the timer core consumes it. Depends on dlyt_pkg.
`default_nettype none

module dlyt_in (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [dlyt_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic [dlyt_pkg::IN_USER_W-1:0] s_tuser,
	input  wire logic                           take,
	output logic                                valid_s1,
	output dlyt_pkg::item_t                     item_s1
);

	logic            vld_s1;
	dlyt_pkg::item_t itm_s1;

	assign s_tready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			itm_s1.action      <= s_tuser;
			itm_s1.force_req   <= s_tdata[0];
			itm_s1.duration_ms <= s_tdata[32:1];
			itm_s1.percentage  <= s_tdata[40:33];
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1  = itm_s1;

endmodule

`default_nettype wire

@@ rtl/core/dlyt_core.sv @@
// Timer core: phase, level, elapsed tick count and one-shot state, updated once
// per consumed item. Depends on dlyt_pkg.
`default_nettype none

module dlyt_core #(
	parameter int TIME_BITS = dlyt_pkg::TIME_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire dlyt_pkg::item_t item,
	input  wire dlyt_pkg::cfg_t  cfg,
	output dlyt_pkg::result_t res
);

	// elapsed*100 is kept alongside elapsed so percentage one-shots compare
	// against the raw product instead of product/100
	localparam int XW  = TIME_BITS + 7;
	localparam int CW  = (TIME_BITS + 8 > dlyt_pkg::PROD_W) ? TIME_BITS + 8 : dlyt_pkg::PROD_W;
	localparam int DW  = (TIME_BITS > dlyt_pkg::CFG_W) ? TIME_BITS : dlyt_pkg::CFG_W;
	localparam int PW  = dlyt_pkg::PROD_W;

	dlyt_pkg::phase_t     phase_q, phase_d;
	logic                 level_q, level_d;
	logic [TIME_BITS-1:0] elapsed_q, elapsed_d, e_inc;
	logic [XW-1:0]        ex100_q, ex100_d, x_inc;
	logic [PW-1:0]        os_q, os_d;
	logic                 os_pct_q, os_pct_d;
	logic                 ev, drv;

	logic          os_nz, os_hit, auto_hit, dly_hit, on_delayed;
	logic [PW-1:0] pct_prod;

	assign e_inc = (&elapsed_q) ? elapsed_q : elapsed_q + TIME_BITS'(1);
	assign x_inc = (&elapsed_q) ? ex100_q : ex100_q + XW'(100);

	// floor(P/100) > 0  <=>  P >= 100;  e >= floor(P/100)  <=>  100*(e+1) > P
	assign os_nz  = os_pct_q ? (os_q >= PW'(100)) : (os_q != '0);
	assign os_hit = os_pct_q ? ((CW'(x_inc) + CW'(100)) > CW'(os_q))
	                         : (DW'(e_inc) >= DW'(os_q[dlyt_pkg::DUR_W-1:0]));
	assign auto_hit = DW'(e_inc) >= DW'(cfg.auto_off_ms);
	assign dly_hit  = DW'(e_inc) >= DW'(cfg.on_delay_ms);

	assign on_delayed = (cfg.on_delay_ms != '0) && (phase_q != dlyt_pkg::PH_ON);
	assign pct_prod   = PW'(cfg.auto_off_ms) * PW'(item.percentage);

	always_comb begin
		phase_d   = phase_q;
		level_d   = level_q;
		elapsed_d = elapsed_q;
		ex100_d   = ex100_q;
		os_d      = os_q;
		os_pct_d  = os_pct_q;
		ev        = 1'b0;
		drv       = 1'b0;
		case (item.action)
			dlyt_pkg::ACT_TICK: begin
				elapsed_d = e_inc;
				ex100_d   = x_inc;
				if ((os_nz && level_q && os_hit) ||
				    (!(os_nz && level_q) && cfg.auto_off_enable && level_q && auto_hit)) begin
					os_d     = '0;
					os_pct_d = 1'b0;
					phase_d  = dlyt_pkg::PH_OFF;
					level_d  = 1'b0;
					drv      = 1'b1;
					ev       = 1'b1;
				end else if (phase_q == dlyt_pkg::PH_WAIT && dly_hit) begin
					// a pending one-shot time is kept across the on-delay
					phase_d   = dlyt_pkg::PH_ON;
					elapsed_d = '0;
					ex100_d   = '0;
					level_d   = 1'b1;
					drv       = !level_q;
				end
			end
			dlyt_pkg::ACT_ON,
			dlyt_pkg::ACT_ON_TIME,
			dlyt_pkg::ACT_ON_PCT: begin
				if (item.action != dlyt_pkg::ACT_ON_PCT ||
				    item.percentage inside {[8'd1:8'd100]}) begin
					elapsed_d = '0;
					ex100_d   = '0;
					os_d      = '0;
					os_pct_d  = 1'b0;
					if (on_delayed) begin
						phase_d = dlyt_pkg::PH_WAIT;
					end else begin
						phase_d = dlyt_pkg::PH_ON;
						level_d = 1'b1;
						drv     = !level_q || item.force_req;
					end
					if (item.action == dlyt_pkg::ACT_ON_TIME) begin
						os_d = PW'(item.duration_ms);
					end else if (item.action == dlyt_pkg::ACT_ON_PCT) begin
						os_d     = pct_prod;
						os_pct_d = 1'b1;
					end
				end
			end
			dlyt_pkg::ACT_OFF: begin
				os_d     = '0;
				os_pct_d = 1'b0;
				phase_d  = dlyt_pkg::PH_OFF;
				level_d  = 1'b0;
				drv      = level_q || item.force_req;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= dlyt_pkg::PH_OFF;
			level_q   <= 1'b0;
			elapsed_q <= '0;
			ex100_q   <= '0;
			os_q      <= '0;
			os_pct_q  <= 1'b0;
		end else if (en) begin
			phase_q   <= phase_d;
			level_q   <= level_d;
			elapsed_q <= elapsed_d;
			ex100_q   <= ex100_d;
			os_q      <= os_d;
			os_pct_q  <= os_pct_d;
		end
	end

	assign res.output_on      = level_d;
	assign res.phase          = phase_d;
	assign res.auto_off_event = ev;
	assign res.drive_strobe   = drv;

endmodule

`default_nettype wire

@@ rtl/core/dlyt_out.sv @@
// Result register driving the master stream; holds a result while the receiver stalls.
// Depends on dlyt_pkg.
`default_nettype none

module dlyt_out (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            load,
	input  wire dlyt_pkg::result_t               res,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [dlyt_pkg::OUT_DATA_W-1:0]      m_tdata
);

	logic              vld_q;
	dlyt_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {3'b000, res_q.drive_strobe, res_q.auto_off_event,
	                   res_q.phase, res_q.output_on};

endmodule

`default_nettype wire

@@ rtl/core/delayed_on_auto_off_output_timer.sv @@
// Delayed-on / auto-off output timer, top level.
// Instantiates dlyt_cfg, dlyt_in, dlyt_core and dlyt_out; uses dlyt_pkg.
//
// Usage:
//  - Slave stream carries one command item per transfer: tuser holds the action
//    (tick, on, on for a time, on for a percentage, off); tdata the arguments.
//  - Master stream returns exactly one result item per command: output level,
//    phase, auto-off event and pin drive strobe.
//  - Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//    only while no item is in flight.
//  - Path: an accepted item goes into the input register; when the result
//    register is empty or being taken, the core updates its state and the
//    result is loaded into the result register and shown on the master stream.
//  - Throughput: 1 item per cycle while the receiver does not stall; the
//    combinational compare/update path in the core sustains this figure.
//  - When the receiver stalls, the result register holds and one more item
//    waits in the input register; tready drops only when both are full.
//  - Reset: output off, phase off, tick count and one-shot cleared,
//    configuration registers zero. No items are held after reset.
`default_nettype none

module delayed_on_auto_off_output_timer #(
	parameter int TIME_BITS = dlyt_pkg::TIME_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// slave stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// tdata: force_req[0], duration_ms[32:1], percentage[40:33], zero fill
	input  wire logic [dlyt_pkg::IN_DATA_W-1:0]  s_tdata,
	// tuser: action[2:0]
	input  wire logic [dlyt_pkg::IN_USER_W-1:0]  s_tuser,
	// master stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// tdata: output_on[0], phase[2:1], auto_off_event[3], drive_strobe[4], zero fill
	output logic [dlyt_pkg::OUT_DATA_W-1:0]      m_tdata,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [dlyt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dlyt_pkg::CFG_W-1:0]      cfg_data
);

	dlyt_pkg::cfg_t    cfg;
	dlyt_pkg::item_t   item_s1;
	dlyt_pkg::result_t res;
	logic              valid_s1;
	logic              adv;

	assign adv = valid_s1 && (!m_tvalid || m_tready);

	dlyt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dlyt_in u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dlyt_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	dlyt_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

@@ rtl/core/dlyt_checker.sv @@
// Port-level checks for the output timer and the bind that attaches them.
// Depends on dlyt_pkg and on the top level delayed_on_auto_off_output_timer.
`default_nettype none

module dlyt_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [dlyt_pkg::OUT_DATA_W-1:0] m_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// level follows phase: on exactly when phase is on
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == dlyt_pkg::PH_ON)))
		else $error("output level disagrees with phase");

	// a timeout leaves the output off and drives the pin
	a_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[0] && m_tdata[4]
		&& (m_tdata[2:1] == dlyt_pkg::PH_OFF))
		else $error("auto-off event without switching off");

	// waiting phase never drives the pin
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:1] == dlyt_pkg::PH_WAIT) |-> !m_tdata[4] && !m_tdata[3])
		else $error("pin driven while waiting for on-delay");

endmodule

bind delayed_on_auto_off_output_timer dlyt_checker u_dlyt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/delayed_on_auto_off_output_timer_test.sv @@
// Self-checking bench for delayed_on_auto_off_output_timer: directed commands, then random
// ticks and commands over several timer settings, checked item by item against a local model.
// Depends on dlyt_pkg and the timer RTL only.
`timescale 1ns / 100ps

module delayed_on_auto_off_output_timer_test;

	localparam int          IDLE_LIMIT  = 2000;
	localparam int          TAIL_CYCLES = 4;
	localparam int          LONG_HOLD   = 90;
	localparam int          PCT_FULL    = 100;
	localparam logic [2:0]  ACT_RSVD5   = 3'd5;
	localparam logic [2:0]  ACT_RSVD7   = 3'd7;
	localparam logic [31:0] TIME_MAX    = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n = 1'b0;

	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	// tdata: force_req[0], duration_ms[32:1], percentage[40:33], zero fill
	logic [dlyt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	// tuser: action[2:0]
	logic [dlyt_pkg::IN_USER_W-1:0]  s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// tdata: output_on[0], phase[2:1], auto_off_event[3], drive_strobe[4], zero fill
	logic [dlyt_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_we = 1'b0;
	logic [dlyt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dlyt_pkg::CFG_W-1:0]      cfg_data = '0;

	delayed_on_auto_off_output_timer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// timer model state and its copy of the registers
	dlyt_pkg::phase_t mdl_phase   = dlyt_pkg::PH_OFF;
	logic             mdl_level   = 1'b0;
	logic [31:0]      mdl_elapsed = '0;
	logic [31:0]      mdl_oneshot = '0;
	logic             mdl_driven;
	logic [31:0]      mdl_on_delay = '0;
	logic             mdl_ao_en    = 1'b0;
	logic [31:0]      mdl_ao_ms    = '0;

	dlyt_pkg::item_t   pending_cmds[$];
	dlyt_pkg::result_t expected_results[$];
	dlyt_pkg::item_t   cur_cmd;

	int err_cnt      = 0;
	int cmds_sent    = 0;
	int results_seen = 0;
	int timeouts     = 0;
	int settings_run = 0;
	int idle_cycles  = 0;

	function automatic void drive_level(input logic lvl, input logic frc);
		if (lvl != mdl_level || frc)
			mdl_driven = 1'b1;
		mdl_level = lvl;
	endfunction

	function automatic void switch_on(input logic frc);
		mdl_oneshot = '0;
		if (mdl_on_delay != 0 && mdl_phase != dlyt_pkg::PH_ON) begin
			// on-delay pending: pin untouched even when forced
			mdl_elapsed = '0;
			mdl_phase   = dlyt_pkg::PH_WAIT;
		end else begin
			mdl_phase   = dlyt_pkg::PH_ON;
			mdl_elapsed = '0;
			drive_level(1'b1, frc);
		end
	endfunction

	function automatic void switch_off(input logic frc);
		mdl_oneshot = '0;
		mdl_phase   = dlyt_pkg::PH_OFF;
		drive_level(1'b0, frc);
	endfunction

	function automatic dlyt_pkg::result_t timer_step(input dlyt_pkg::item_t cmd);
		dlyt_pkg::result_t           res;
		logic                        evt;
		logic [dlyt_pkg::PROD_W-1:0] prod;
		evt        = 1'b0;
		mdl_driven = 1'b0;
		case (cmd.action)
			dlyt_pkg::ACT_TICK: begin
				if (mdl_elapsed != TIME_MAX)
					mdl_elapsed = mdl_elapsed + 1;
				if (mdl_oneshot != 0 && mdl_level) begin
					if (mdl_elapsed >= mdl_oneshot) begin
						switch_off(1'b0);
						evt = 1'b1;
					end
				end else if (mdl_ao_en && mdl_level) begin
					if (mdl_elapsed >= mdl_ao_ms) begin
						switch_off(1'b0);
						evt = 1'b1;
					end
				end
				// wait over: one-shot time stays armed
				if (mdl_phase == dlyt_pkg::PH_WAIT && mdl_elapsed >= mdl_on_delay) begin
					mdl_phase   = dlyt_pkg::PH_ON;
					mdl_elapsed = '0;
					drive_level(1'b1, 1'b0);
				end
			end
			dlyt_pkg::ACT_ON: switch_on(cmd.force_req);
			dlyt_pkg::ACT_ON_TIME: begin
				switch_on(cmd.force_req);
				mdl_oneshot = cmd.duration_ms;
			end
			dlyt_pkg::ACT_ON_PCT: begin
				if (cmd.percentage >= 1 && cmd.percentage <= PCT_FULL) begin
					switch_on(cmd.force_req);
					prod        = dlyt_pkg::PROD_W'(mdl_ao_ms) *
						dlyt_pkg::PROD_W'(cmd.percentage);
					mdl_oneshot = 32'(prod / PCT_FULL);
				end
			end
			dlyt_pkg::ACT_OFF: switch_off(cmd.force_req);
			default: ;
		endcase
		res.output_on      = mdl_level;
		res.phase          = mdl_phase;
		res.auto_off_event = evt;
		res.drive_strobe   = mdl_driven;
		return res;
	endfunction

	// sender: bursts of random length separated by random gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(timer_step(cur_cmd));
				cmds_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || pending_cmds.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					cur_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= cur_cmd.action;
					s_tdata  <= {7'd0, cur_cmd.percentage, cur_cmd.duration_ms,
						cur_cmd.force_req};
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// receiver: random ready modes, plus one long hold-off on request
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int rx_mode   = 0;
	int mode_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		dlyt_pkg::result_t got;
		dlyt_pkg::result_t want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
				$display("[delayed_on_auto_off_output_timer] ERROR");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[4:0];
				results_seen++;
				if (got.auto_off_event)
					timeouts++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %b", $time, got);
					err_cnt++;
				end else begin
					want = expected_results.pop_front();
					if (got.output_on !== want.output_on) begin
						$display("%0t: output_on expected %b actual %b", $time,
							want.output_on, got.output_on);
						err_cnt++;
					end
					if (got.phase !== want.phase) begin
						$display("%0t: phase expected %0d actual %0d", $time,
							want.phase, got.phase);
						err_cnt++;
					end
					if (got.auto_off_event !== want.auto_off_event) begin
						$display("%0t: auto_off_event expected %b actual %b", $time,
							want.auto_off_event, got.auto_off_event);
						err_cnt++;
					end
					if (got.drive_strobe !== want.drive_strobe) begin
						$display("%0t: drive_strobe expected %b actual %b", $time,
							want.drive_strobe, got.drive_strobe);
						err_cnt++;
					end
				end
			end
		end
	end

	function automatic void queue_cmd(input logic [2:0] act, input logic frc,
		input logic [31:0] dur, input logic [7:0] pct);
		dlyt_pkg::item_t cmd;
		cmd.action      = act;
		cmd.force_req   = frc;
		cmd.duration_ms = dur;
		cmd.percentage  = pct;
		pending_cmds.push_back(cmd);
	endfunction

	// ticks most often; one-shot times mostly kept short so they expire within a phase
	function automatic dlyt_pkg::item_t rand_cmd();
		dlyt_pkg::item_t cmd;
		int              pick;
		pick = $urandom_range(0, 99);
		if (pick < 48)
			cmd.action = dlyt_pkg::ACT_TICK;
		else if (pick < 60)
			cmd.action = dlyt_pkg::ACT_ON;
		else if (pick < 72)
			cmd.action = dlyt_pkg::ACT_ON_TIME;
		else if (pick < 84)
			cmd.action = dlyt_pkg::ACT_ON_PCT;
		else if (pick < 97)
			cmd.action = dlyt_pkg::ACT_OFF;
		else
			cmd.action = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
		cmd.force_req = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		if (cmd.action != dlyt_pkg::ACT_ON_TIME || pick == 1)
			cmd.duration_ms = $urandom;
		else if (pick == 0)
			cmd.duration_ms = '0;
		else
			cmd.duration_ms = $urandom_range(1, 40);
		pick = $urandom_range(0, 9);
		if (pick < 7)
			cmd.percentage = 8'($urandom_range(1, PCT_FULL));
		else if (pick == 7)
			cmd.percentage = '0;
		else
			cmd.percentage = 8'($urandom_range(0, 255));
		return cmd;
	endfunction

	task automatic write_reg(input logic [dlyt_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dlyt_pkg::CFG_ON_DELAY:    mdl_on_delay = val;
			dlyt_pkg::CFG_AUTO_OFF_EN: mdl_ao_en    = val[0];
			dlyt_pkg::CFG_AUTO_OFF_MS: mdl_ao_ms    = val;
			default: ;
		endcase
	endtask

	task automatic set_timer(input logic [31:0] dly, input logic en, input logic [31:0] ms);
		write_reg(dlyt_pkg::CFG_ON_DELAY, dly);
		write_reg(dlyt_pkg::CFG_AUTO_OFF_EN, {31'd0, en});
		write_reg(dlyt_pkg::CFG_AUTO_OFF_MS, ms);
		settings_run++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [31:0] dly;
		logic        en;
		logic [31:0] ms;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: no on-delay, auto-off disabled
		queue_cmd(dlyt_pkg::ACT_TICK, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_ON, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_ON, 1'b1, '0, '0);       // forced, level unchanged
		queue_cmd(dlyt_pkg::ACT_OFF, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_OFF, 1'b1, '0, '0);
		queue_cmd(dlyt_pkg::ACT_ON_PCT, 1'b1, '0, 8'd0);   // out of range, ignored
		queue_cmd(dlyt_pkg::ACT_ON_PCT, 1'b1, '0, 8'd101);
		queue_cmd(ACT_RSVD5, 1'b1, TIME_MAX, 8'd255);
		wait_drained();

		set_timer(32'd3, 1'b1, 32'd4);
		queue_cmd(dlyt_pkg::ACT_ON, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_TICK, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_TICK, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_ON, 1'b1, '0, '0);       // restarts the wait, no drive
		repeat (3) queue_cmd(dlyt_pkg::ACT_TICK, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_ON_TIME, 1'b0, '0, '0);    // zero time acts as plain on
		queue_cmd(dlyt_pkg::ACT_ON_TIME, 1'b1, 32'd2, '0);
		repeat (2) queue_cmd(dlyt_pkg::ACT_TICK, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_ON_PCT, 1'b0, '0, 8'd50); // one-shot armed across the wait
		repeat (5) queue_cmd(dlyt_pkg::ACT_TICK, 1'b0, '0, '0);
		queue_cmd(dlyt_pkg::ACT_ON, 1'b0, '0, '0);
		wait_drained();
		// on-delay dropped to zero while waiting
		set_timer(32'd0, 1'b0, 32'd4);
		queue_cmd(dlyt_pkg::ACT_TICK, 1'b0, '0, '0);
		wait_drained();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin dly = 32'd0;    en = 1'b1; ms = 32'd0;     end
				1: begin dly = 32'd2;    en = 1'b1; ms = 32'd10;    end
				2: begin dly = 32'd5;    en = 1'b0; ms = 32'd50;    end
				3: begin dly = TIME_MAX; en = 1'b1; ms = TIME_MAX;  end
				4: begin dly = 32'd1;    en = 1'b1; ms = 32'd200;   end
				5: begin dly = 32'd0;    en = 1'b1; ms = TIME_MAX;  end
				default: begin
					dly = $urandom_range(0, 8);
					en  = 1'($urandom_range(0, 1));
					ms  = $urandom_range(0, 30);
				end
			endcase
			set_timer(dly, en, ms);
			if (ph == 2)
				hold_req = 1'b1;
			repeat (170) pending_cmds.push_back(rand_cmd());
			wait_drained();
		end

		$display("ran %0d commands under %0d timer settings", cmds_sent, settings_run);
		$display("checked %0d results, %0d timeout switch-offs", results_seen, timeouts);
		if (err_cnt == 0 && expected_results.size() == 0) begin
			$display("[delayed_on_auto_off_output_timer] OK");
		end else begin
			$display("[delayed_on_auto_off_output_timer] ERROR");
		end
		$finish;
	end

endmodule
